### rtl/core/ppu_sri_pkg.sv
// Shared types and constants for the PPU scroll register interface.
package ppu_sri_pkg;

    // Operation codes carried by each input transaction
    localparam logic [3:0] OP_CPU_READ  = 4'd0;
    localparam logic [3:0] OP_CPU_WRITE = 4'd1;
    localparam logic [3:0] OP_INCR_X    = 4'd2;
    localparam logic [3:0] OP_INCR_Y    = 4'd3;
    localparam logic [3:0] OP_COPY_H    = 4'd4;
    localparam logic [3:0] OP_COPY_V    = 4'd5;
    localparam logic [3:0] OP_VBLANK    = 4'd6;
    localparam logic [3:0] OP_PRE_CLR   = 4'd7;
    localparam logic [3:0] OP_SPR0_HIT  = 4'd8;

    // CPU register numbers
    localparam logic [2:0] REG_CTRL     = 3'd0;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    localparam int VRAM_ADDR_BITS = 14;
    localparam int OAM_BYTES      = 256;
    localparam int OAM_ADDR_BITS  = $clog2(OAM_BYTES);
    localparam int V_BITS         = 15;
    localparam int NUM_REGS       = 8;

    localparam logic [VRAM_ADDR_BITS-1:0] PALETTE_LIMIT = 14'h3EFF;
    localparam logic [VRAM_ADDR_BITS-1:0] ATTR_BASE     = 14'h23C0;
    localparam logic [V_BITS-1:0]         COPY_H_MASK   = 15'h041F;
    localparam logic [V_BITS-1:0]         COPY_V_MASK   = 15'h7BE0;
    localparam logic [V_BITS-1:0]         FINE_Y_STEP   = 15'h1000;

    typedef logic [V_BITS-1:0] t_vaddr;

    typedef struct packed {
        logic [7:0]                read_data;
        logic [VRAM_ADDR_BITS-1:0] access_addr;
        logic                      mem_read;
        logic                      mem_write;
        logic [7:0]                write_data;
        logic                      oam_write;
        logic [OAM_ADDR_BITS-1:0]  oam_addr;
        logic                      nmi_request;
        logic [2:0]                fine_x_out;
        t_vaddr                    scroll_v;
        logic [VRAM_ADDR_BITS-1:0] attr_addr;
    } t_result;

endpackage

### rtl/core/ppu_scroll_register_interface_top.sv
// PPU CPU register file with loopy scroll/address registers, one transaction per cycle unless stalled.
// Each transaction passes through the input register, then single-pass update logic into
// the result register. Throughput: one transaction per cycle; input stalls only while a
// stalled result is held and the input register is full. Reset (synchronous, active low)
// clears all scroll, address, buffer and register state and empties both pipeline
// registers.
module ppu_scroll_register_interface_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [3:0]                            i_op,
    input  logic [2:0]                            i_reg_sel,
    input  logic [7:0]                            i_cpu_wdata,
    input  logic [7:0]                            i_mem_rdata,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [7:0]                            o_read_data,
    output logic [ppu_sri_pkg::VRAM_ADDR_BITS-1:0] o_access_addr,
    output logic                                  o_mem_read,
    output logic                                  o_mem_write,
    output logic [7:0]                            o_write_data,
    output logic                                  o_oam_write,
    output logic [ppu_sri_pkg::OAM_ADDR_BITS-1:0]  o_oam_addr,
    output logic                                  o_nmi_request,
    output logic [2:0]                            o_fine_x_out,
    output logic [ppu_sri_pkg::V_BITS-1:0]         o_scroll_v,
    output logic [ppu_sri_pkg::VRAM_ADDR_BITS-1:0] o_attr_addr
);
    import ppu_sri_pkg::*;

    // input register
    logic       r_in_valid;
    logic [3:0] r_op;
    logic [2:0] r_reg_sel;
    logic [7:0] r_wdata;
    logic [7:0] r_mdata;

    // architectural state
    logic [7:0]               r_lw [NUM_REGS];
    logic [7:0]               n_lw [NUM_REGS];
    t_vaddr                   r_cur_addr, n_cur_addr;
    t_vaddr                   r_tmp_addr, n_tmp_addr;
    logic [2:0]               r_fine_x, n_fine_x;
    logic                     r_toggle, n_toggle;
    logic [7:0]               r_rbuf, n_rbuf;
    logic [OAM_ADDR_BITS-1:0] r_oam_ptr, n_oam_ptr;

    // result register
    logic    r_out_valid;
    t_result r_res, n_res;

    logic advance;
    logic [VRAM_ADDR_BITS-1:0] vaddr;
    t_vaddr inc;
    logic [4:0] row;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign vaddr   = r_cur_addr[VRAM_ADDR_BITS-1:0];
    assign inc     = r_lw[REG_CTRL][2] ? t_vaddr'(32) : t_vaddr'(1);
    assign row     = r_cur_addr[9:5];

    always_comb begin
        n_lw       = r_lw;
        n_cur_addr = r_cur_addr;
        n_tmp_addr = r_tmp_addr;
        n_fine_x   = r_fine_x;
        n_toggle   = r_toggle;
        n_rbuf     = r_rbuf;
        n_oam_ptr  = r_oam_ptr;
        n_res      = '0;

        case (r_op)
            OP_CPU_READ: begin
                if (r_reg_sel == REG_STATUS) begin
                    n_res.read_data     = r_lw[REG_STATUS];
                    n_lw[REG_STATUS][7] = 1'b0;
                    n_toggle            = 1'b0;
                end else if (r_reg_sel == REG_DATA) begin
                    n_res.access_addr = vaddr;
                    n_res.mem_read    = 1'b1;
                    // buffered below palette space, direct above
                    if (vaddr <= PALETTE_LIMIT) begin
                        n_res.read_data = r_rbuf;
                        n_rbuf          = r_mdata;
                    end else begin
                        n_res.read_data = r_mdata;
                    end
                    n_cur_addr = r_cur_addr + inc;
                end else begin
                    n_res.read_data = r_lw[r_reg_sel];
                end
            end
            OP_CPU_WRITE: begin
                case (r_reg_sel)
                    REG_CTRL: begin
                        n_lw[REG_CTRL]    = r_wdata;
                        n_tmp_addr[11:10] = r_wdata[1:0];
                    end
                    REG_STATUS: begin
                    end
                    REG_OAM_ADDR: begin
                        n_oam_ptr          = r_wdata;
                        n_lw[REG_OAM_ADDR] = r_wdata;
                    end
                    REG_OAM_DATA: begin
                        n_res.oam_write    = 1'b1;
                        n_res.oam_addr     = r_oam_ptr;
                        n_res.write_data   = r_wdata;
                        n_oam_ptr          = r_oam_ptr + 1'b1;
                        n_lw[REG_OAM_DATA] = r_wdata;
                    end
                    REG_SCROLL: begin
                        if (!r_toggle) begin
                            n_tmp_addr[4:0] = r_wdata[7:3];
                            n_fine_x        = r_wdata[2:0];
                        end else begin
                            n_tmp_addr[9:5]   = r_wdata[7:3];
                            n_tmp_addr[14:12] = r_wdata[2:0];
                        end
                        n_toggle         = !r_toggle;
                        n_lw[REG_SCROLL] = r_wdata;
                    end
                    REG_ADDR: begin
                        if (!r_toggle) begin
                            n_tmp_addr[14:8] = {1'b0, r_wdata[5:0]};
                        end else begin
                            n_tmp_addr[7:0] = r_wdata;
                            n_cur_addr      = {r_tmp_addr[14:8], r_wdata};
                        end
                        n_toggle       = !r_toggle;
                        n_lw[REG_ADDR] = r_wdata;
                    end
                    REG_DATA: begin
                        n_res.access_addr = vaddr;
                        n_res.mem_write   = 1'b1;
                        n_res.write_data  = r_wdata;
                        n_cur_addr        = r_cur_addr + inc;
                    end
                    default: begin
                        n_lw[r_reg_sel] = r_wdata;
                    end
                endcase
            end
            OP_INCR_X: begin
                if (r_cur_addr[4:0] == 5'd31) begin
                    n_cur_addr[4:0] = 5'd0;
                    n_cur_addr[10]  = !r_cur_addr[10];
                end else begin
                    n_cur_addr = r_cur_addr + t_vaddr'(1);
                end
            end
            OP_INCR_Y: begin
                if (r_cur_addr[14:12] != 3'd7) begin
                    n_cur_addr = r_cur_addr + FINE_Y_STEP;
                end else begin
                    n_cur_addr[14:12] = 3'd0;
                    if (row == 5'd29) begin
                        n_cur_addr[9:5] = 5'd0;
                        n_cur_addr[11]  = !r_cur_addr[11];
                    end else if (row == 5'd31) begin
                        n_cur_addr[9:5] = 5'd0;
                    end else begin
                        n_cur_addr[9:5] = row + 5'd1;
                    end
                end
            end
            OP_COPY_H: begin
                n_cur_addr = (r_cur_addr & ~COPY_H_MASK) | (r_tmp_addr & COPY_H_MASK);
            end
            OP_COPY_V: begin
                n_cur_addr = (r_cur_addr & ~COPY_V_MASK) | (r_tmp_addr & COPY_V_MASK);
            end
            OP_VBLANK: begin
                n_lw[REG_STATUS][7] = 1'b1;
                n_res.nmi_request   = r_lw[REG_CTRL][7];
            end
            OP_PRE_CLR: begin
                n_lw[REG_STATUS][7:6] = 2'b00;
            end
            OP_SPR0_HIT: begin
                n_lw[REG_STATUS][6] = 1'b1;
            end
            default: begin
            end
        endcase

        n_res.fine_x_out = n_fine_x;
        n_res.scroll_v   = n_cur_addr;
        n_res.attr_addr  = ATTR_BASE | {2'b00, n_cur_addr[11:10], 4'b0000,
                                        n_cur_addr[9:7], n_cur_addr[4:2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_REGS; k++) begin
                r_lw[k] <= '0;
            end
            r_cur_addr <= '0;
            r_tmp_addr <= '0;
            r_fine_x   <= '0;
            r_toggle   <= 1'b0;
            r_rbuf     <= '0;
            r_oam_ptr  <= '0;
        end else begin
            // take a new transaction whenever the input register is free or moving
            if (!o_stall) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_lw        <= n_lw;
                r_cur_addr  <= n_cur_addr;
                r_tmp_addr  <= n_tmp_addr;
                r_fine_x    <= n_fine_x;
                r_toggle    <= n_toggle;
                r_rbuf      <= n_rbuf;
                r_oam_ptr   <= n_oam_ptr;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_op      <= i_op;
            r_reg_sel <= i_reg_sel;
            r_wdata   <= i_cpu_wdata;
            r_mdata   <= i_mem_rdata;
        end
        if (advance) begin
            r_res <= n_res;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_data   = r_res.read_data;
    assign o_access_addr = r_res.access_addr;
    assign o_mem_read    = r_res.mem_read;
    assign o_mem_write   = r_res.mem_write;
    assign o_write_data  = r_res.write_data;
    assign o_oam_write   = r_res.oam_write;
    assign o_oam_addr    = r_res.oam_addr;
    assign o_nmi_request = r_res.nmi_request;
    assign o_fine_x_out  = r_res.fine_x_out;
    assign o_scroll_v    = r_res.scroll_v;
    assign o_attr_addr   = r_res.attr_addr;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_stall)
        else $error("input stalled with empty input register");

    a_state_holds_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |=> $stable(r_cur_addr) && $stable(r_tmp_addr))
        else $error("scroll state changed while result was stalled");

    a_single_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_mem_read, o_mem_write, o_oam_write}) <= 1)
        else $error("more than one memory access in one result");

    a_attr_follows_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_attr_addr[11:10] == o_scroll_v[11:10])
        else $error("attribute address out of step with scroll address");

endmodule
